### rtl/lrues_pkg.sv
// shared types and constants for the lru eviction selector
`timescale 1ns / 1ps
package lrues_pkg;

   // widths fixed by the item and result formats
   localparam int TIME_W    = 64;
   localparam int BYTES_W   = 64;
   localparam int SEL_IDX_W = 6;
   localparam int CNT_W     = 7;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 64;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 2;

   // rsp tuser bit positions
   localparam int RSP_USER_HAS_SEL = 0;
   localparam int RSP_USER_OVF     = 1;

   // selection job handed from the loader to the walker
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             overflowed;
   } job_type;

endpackage

### rtl/lru_eviction_selector.sv
// Loading accepts one candidate beat per cycle while the job queue has room and the
// loader is unlocked; the final candidate locks the loader. A selection walks the
// sorted order with a full store scan per step over the n loaded candidates, through
// one store read port; a step that picks also passes through an emit state.
// Synchronous active-high reset clears the deficits, counters, queue and result stage;
// candidate stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps
module lru_eviction_selector import lrues_pkg::*; #(
   parameter int MAX_CANDIDATES = 64,
   parameter int NUM_DISKS      = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request beat
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // ready_time, last_access_time, footprint_disk0..NUM_DISKS-1
   input  logic [2*TIME_W+NUM_DISKS*BYTES_W-1:0] req_tdata,
   // is_protected
   input  logic                                  req_tuser,
   input  logic                                  req_tlast,
   // result beat
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // selected_index, zero pad
   output logic [RSP_DATA_W-1:0]                 rsp_tdata,
   // has_selection, overflowed
   output logic [RSP_USER_W-1:0]                 rsp_tuser,
   output logic                                  rsp_tlast,
   // deficit register writes
   input  logic                                  csr_we,
   input  logic [CSR_ADDR_W-1:0]                 csr_addr,
   input  logic [CSR_DATA_W-1:0]                 csr_wdata
);

   localparam int IW = $clog2(MAX_CANDIDATES);

   logic [NUM_DISKS*BYTES_W-1:0] deficit_ff;
   logic                         wr_en, wr_prot, job_push, job_full, job_pop;
   logic                         job_empty, walk_done;
   logic [IW-1:0]                wr_addr;
   logic [TIME_W-1:0]            wr_time;
   logic [NUM_DISKS*BYTES_W-1:0] wr_fp;
   job_type                      job_in, job_out;

   // deficit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         deficit_ff <= '0;
      end else begin
         for (int d = 0; d < NUM_DISKS; d++) begin
            if (csr_we && csr_addr == CSR_ADDR_W'(d)) begin
               deficit_ff[d*BYTES_W +: BYTES_W] <= csr_wdata;
            end
         end
      end
   end

   lrues_front #(
      .MAX_CANDIDATES (MAX_CANDIDATES),
      .NUM_DISKS      (NUM_DISKS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_time    (wr_time),
      .wr_prot    (wr_prot),
      .wr_fp      (wr_fp),
      .job_push   (job_push),
      .job_data   (job_in),
      .job_full   (job_full),
      .walk_done  (walk_done)
   );

   lrues_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .empty     (job_empty),
      .pop_data  (job_out)
   );

   lrues_back #(
      .MAX_CANDIDATES (MAX_CANDIDATES),
      .NUM_DISKS      (NUM_DISKS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_time    (wr_time),
      .wr_prot    (wr_prot),
      .wr_fp      (wr_fp),
      .deficit    (deficit_ff),
      .job_empty  (job_empty),
      .job_data   (job_out),
      .job_pop    (job_pop),
      .walk_done  (walk_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/lrues_front.sv
// loader: accepts candidates, computes effective time, issues selection jobs
`timescale 1ns / 1ps
module lrues_front import lrues_pkg::*; #(
   parameter int MAX_CANDIDATES = 64,
   parameter int NUM_DISKS      = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [2*TIME_W+NUM_DISKS*BYTES_W-1:0] req_tdata,
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   output logic                              wr_en,
   output logic [$clog2(MAX_CANDIDATES)-1:0] wr_addr,
   output logic [TIME_W-1:0]                 wr_time,
   output logic                              wr_prot,
   output logic [NUM_DISKS*BYTES_W-1:0]      wr_fp,
   output logic                              job_push,
   output job_type                           job_data,
   input  logic                              job_full,
   input  logic                              walk_done
);

   localparam int IW = $clog2(MAX_CANDIDATES);
   localparam int CW = $clog2(MAX_CANDIDATES + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          lock_ff, lock_in;
   logic          accept, room;
   logic [TIME_W-1:0] ready_time, access_time;

   assign ready_time  = req_tdata[TIME_W-1:0];
   assign access_time = req_tdata[2*TIME_W-1:TIME_W];

   assign req_tready = !lock_ff && !job_full;
   assign accept     = req_tvalid && req_tready;
   assign room       = count_ff != CW'(MAX_CANDIDATES);

   // store write for a candidate that fits
   assign wr_en   = accept && room;
   assign wr_addr = count_ff[IW-1:0];
   assign wr_time = (ready_time > access_time) ? ready_time : access_time;
   assign wr_prot = req_tuser;
   assign wr_fp   = req_tdata[2*TIME_W +: NUM_DISKS*BYTES_W];

   // job on the final candidate
   assign job_push            = accept && req_tlast;
   assign job_data.count      = CNT_W'(room ? count_ff + CW'(1) : count_ff);
   assign job_data.overflowed = ovf_ff || !room;

   // load counter, overflow flag and store lock
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      lock_in  = lock_ff;
      if (walk_done) begin
         lock_in = 1'b0;
      end
      if (accept) begin
         if (req_tlast) begin
            count_in = '0;
            ovf_in   = 1'b0;
            lock_in  = 1'b1;
         end else if (room) begin
            count_in = count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         lock_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         lock_ff  <= lock_in;
      end
   end

endmodule

### rtl/lrues_queue.sv
// two-entry job queue between loader and walker
`timescale 1ns / 1ps
module lrues_queue import lrues_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type pop_data
);

   job_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        do_push, do_pop;

   assign full     = fill_ff == 2'd2;
   assign empty    = fill_ff == 2'd0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/lrues_back.sv
// walker: holds candidate stores, orders by effective time, selects victims
`timescale 1ns / 1ps
module lrues_back import lrues_pkg::*; #(
   parameter int MAX_CANDIDATES = 64,
   parameter int NUM_DISKS      = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [$clog2(MAX_CANDIDATES)-1:0] wr_addr,
   input  logic [TIME_W-1:0]                 wr_time,
   input  logic                              wr_prot,
   input  logic [NUM_DISKS*BYTES_W-1:0]      wr_fp,
   input  logic [NUM_DISKS*BYTES_W-1:0]      deficit,
   input  logic                              job_empty,
   input  job_type                           job_data,
   output logic                              job_pop,
   output logic                              walk_done,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [RSP_DATA_W-1:0]             rsp_tdata,
   output logic [RSP_USER_W-1:0]             rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int IW = $clog2(MAX_CANDIDATES);
   localparam int CW = $clog2(MAX_CANDIDATES + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_SCAN, S_SCAN_END, S_PICK, S_FETCH, S_EVAL, S_EMIT, S_FINISH
   } state_type;

   // candidate stores
   logic [TIME_W-1:0]            et_mem   [MAX_CANDIDATES];
   logic                         prot_mem [MAX_CANDIDATES];
   logic [NUM_DISKS*BYTES_W-1:0] fp_mem   [MAX_CANDIDATES];

   logic [IW-1:0]                rd_addr;
   logic [TIME_W-1:0]            rd_et_ff;
   logic                         rd_prot_ff;
   logic [NUM_DISKS*BYTES_W-1:0] rd_fp_ff;
   logic [IW-1:0]                rd_idx_ff;
   logic                         cmp_vld_ff, cmp_vld_in;

   state_type         state_ff, state_in;
   logic [CW-1:0]     n_ff, n_in;
   logic              ovf_ff, ovf_in;
   logic [IW-1:0]     scan_ptr_ff, scan_ptr_in;
   logic              have_prev_ff, have_prev_in;
   logic [TIME_W-1:0] prev_t_ff, prev_t_in;
   logic [IW-1:0]     prev_i_ff, prev_i_in;
   logic              best_vld_ff, best_vld_in;
   logic [TIME_W-1:0] best_t_ff, best_t_in;
   logic [IW-1:0]     best_i_ff, best_i_in;
   logic              pend_vld_ff, pend_vld_in;
   logic [IW-1:0]     pend_i_ff, pend_i_in;
   logic [BYTES_W-1:0] rel_ff [NUM_DISKS];
   logic [BYTES_W-1:0] rel_in [NUM_DISKS];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [NUM_DISKS-1:0] unmet, adds_lane;
   logic                 all_met, adds, after_prev, beats_best, rsp_free;
   logic [BYTES_W:0]     sum [NUM_DISKS];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // store writes from the loader
   always_ff @(posedge clock) begin
      if (wr_en) begin
         et_mem[wr_addr]   <= wr_time;
         prot_mem[wr_addr] <= wr_prot;
         fp_mem[wr_addr]   <= wr_fp;
      end
   end

   // registered store read
   assign rd_addr = (state_ff == S_SCAN) ? scan_ptr_ff : best_i_ff;

   always_ff @(posedge clock) begin
      rd_et_ff   <= et_mem[rd_addr];
      rd_prot_ff <= prot_mem[rd_addr];
      rd_fp_ff   <= fp_mem[rd_addr];
      rd_idx_ff  <= rd_addr;
   end

   // per-disk deficit status and saturating release sums
   always_comb begin
      for (int d = 0; d < NUM_DISKS; d++) begin
         unmet[d] = (deficit[d*BYTES_W +: BYTES_W] != '0) &&
                    (rel_ff[d] < deficit[d*BYTES_W +: BYTES_W]);
         adds_lane[d] = (rd_fp_ff[d*BYTES_W +: BYTES_W] != '0) && unmet[d];
         sum[d] = {1'b0, rel_ff[d]} + {1'b0, rd_fp_ff[d*BYTES_W +: BYTES_W]};
      end
   end

   assign all_met = ~|unmet;
   assign adds    = |adds_lane;

   // ordering by (effective time, load index)
   assign after_prev = !have_prev_ff || (rd_et_ff > prev_t_ff) ||
                       ((rd_et_ff == prev_t_ff) && (rd_idx_ff > prev_i_ff));
   assign beats_best = !best_vld_ff || (rd_et_ff < best_t_ff);

   // walk sequencer
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      ovf_in       = ovf_ff;
      scan_ptr_in  = scan_ptr_ff;
      have_prev_in = have_prev_ff;
      prev_t_in    = prev_t_ff;
      prev_i_in    = prev_i_ff;
      best_vld_in  = best_vld_ff;
      best_t_in    = best_t_ff;
      best_i_in    = best_i_ff;
      pend_vld_in  = pend_vld_ff;
      pend_i_in    = pend_i_ff;
      rel_in       = rel_ff;
      cmp_vld_in   = 1'b0;
      job_pop      = 1'b0;
      walk_done    = 1'b0;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;

      // minimum search over the part of the order not yet walked
      if (cmp_vld_ff && after_prev && beats_best) begin
         best_vld_in = 1'b1;
         best_t_in   = rd_et_ff;
         best_i_in   = rd_idx_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (!job_empty) begin
               job_pop      = 1'b1;
               n_in         = CW'(job_data.count);
               ovf_in       = job_data.overflowed;
               have_prev_in = 1'b0;
               pend_vld_in  = 1'b0;
               for (int d = 0; d < NUM_DISKS; d++) begin
                  rel_in[d] = '0;
               end
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (all_met) begin
               state_in = S_FINISH;
            end else begin
               scan_ptr_in = '0;
               best_vld_in = 1'b0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            cmp_vld_in = 1'b1;
            if (CW'(scan_ptr_ff) == n_ff - CW'(1)) begin
               state_in = S_SCAN_END;
            end else begin
               scan_ptr_in = scan_ptr_ff + IW'(1);
            end
         end
         S_SCAN_END: begin
            state_in = S_PICK;
         end
         S_PICK: begin
            state_in = best_vld_ff ? S_FETCH : S_FINISH;
         end
         S_FETCH: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            have_prev_in = 1'b1;
            prev_t_in    = best_t_ff;
            prev_i_in    = best_i_ff;
            state_in     = (!rd_prot_ff && adds) ? S_EMIT : S_CHECK;
         end
         S_EMIT: begin
            if (!pend_vld_ff || rsp_free) begin
               if (pend_vld_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = RSP_DATA_W'(pend_i_ff);
                  rsp_user_in  = '0;
                  rsp_user_in[RSP_USER_HAS_SEL] = 1'b1;
                  rsp_user_in[RSP_USER_OVF]     = ovf_ff;
                  rsp_last_in  = 1'b0;
               end
               pend_vld_in = 1'b1;
               pend_i_in   = best_i_ff;
               for (int d = 0; d < NUM_DISKS; d++) begin
                  rel_in[d] = sum[d][BYTES_W] ? '1 : sum[d][BYTES_W-1:0];
               end
               state_in = S_CHECK;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_vld_ff ? RSP_DATA_W'(pend_i_ff) : '0;
               rsp_user_in  = '0;
               rsp_user_in[RSP_USER_HAS_SEL] = pend_vld_ff;
               rsp_user_in[RSP_USER_OVF]     = ovf_ff;
               rsp_last_in  = 1'b1;
               walk_done    = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      ovf_ff       <= ovf_in;
      scan_ptr_ff  <= scan_ptr_in;
      have_prev_ff <= have_prev_in;
      prev_t_ff    <= prev_t_in;
      prev_i_ff    <= prev_i_in;
      best_vld_ff  <= best_vld_in;
      best_t_ff    <= best_t_in;
      best_i_ff    <= best_i_in;
      pend_vld_ff  <= pend_vld_in;
      pend_i_ff    <= pend_i_in;
      rel_ff       <= rel_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

### rtl/lrues_checker.sv
// port-level checks for the lru eviction selector, bound to the top level
`timescale 1ns / 1ps
module lrues_checker import lrues_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tlast
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // an empty answer is the only and final beat, with index zero
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[RSP_USER_HAS_SEL] |-> rsp_tlast && rsp_tdata == '0)
      else $error("malformed empty answer");

   // the final candidate locks the loader for the next cycle
   a_lock: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("loader open right after final candidate");

   // reset leaves no result beat pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat valid after reset");

endmodule

bind lru_eviction_selector lrues_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### verif/testbench.sv
// testbench for the lru eviction selector: scoreboard predictor, random stimulus, stalls
`timescale 1ns / 1ps
module testbench;
   import lrues_pkg::*;

   localparam int NCAND = 64;
   localparam int NDISK = 4;
   localparam int DW = 2*TIME_W + NDISK*BYTES_W;

   typedef struct packed {
      logic [5:0] idx;
      logic       has_sel;
      logic       last;
      logic       ovf;
   } pick_type;

   // eviction predictor and queue of expected picks
   class evict_board;
      logic [63:0] deficit[NDISK];
      logic [63:0] eff[NCAND];
      logic        prot[NCAND];
      logic [63:0] foot[NCAND][NDISK];
      logic [63:0] freed[NDISK];
      int          loaded;
      bit          ovf;
      pick_type    pending[$];
      int          errors;

      function new();
         for (int d = 0; d < NDISK; d++) deficit[d] = 0;
         loaded = 0; ovf = 0; errors = 0;
      endfunction

      function bit unmet(int d);
         return deficit[d] != 0 && freed[d] < deficit[d];
      endfunction

      function bit all_met();
         for (int d = 0; d < NDISK; d++) if (unmet(d)) return 0;
         return 1;
      endfunction

      // note one accepted candidate beat
      function void note_candidate(logic [63:0] rt, logic [63:0] la, logic p,
                                   logic [63:0] fp[NDISK], logic lst);
         int order[NCAND];
         int n, pos, c, cnt;
         bit adds;
         pick_type r;
         logic [63:0] room;
         if (loaded < NCAND) begin
            eff[loaded] = (rt > la) ? rt : la;
            prot[loaded] = p;
            for (int d = 0; d < NDISK; d++) foot[loaded][d] = fp[d];
            loaded++;
         end else ovf = 1;
         if (!lst) return;
         n = loaded;
         for (int i = 0; i < n; i++) begin
            pos = i;
            while (pos > 0 && eff[order[pos-1]] > eff[i]) begin
               order[pos] = order[pos-1];
               pos--;
            end
            order[pos] = i;
         end
         for (int d = 0; d < NDISK; d++) freed[d] = 0;
         cnt = 0;
         for (int i = 0; i < n; i++) begin
            c = order[i];
            if (all_met()) break;
            if (prot[c]) continue;
            adds = 0;
            for (int d = 0; d < NDISK; d++) if (foot[c][d] != 0 && unmet(d)) adds = 1;
            if (!adds) continue;
            r.idx = c[5:0]; r.has_sel = 1; r.last = 0; r.ovf = ovf;
            pending = {pending, r};
            cnt++;
            for (int d = 0; d < NDISK; d++) begin
               room = 64'hFFFF_FFFF_FFFF_FFFF - freed[d];
               freed[d] += (foot[c][d] < room) ? foot[c][d] : room;
            end
         end
         if (cnt == 0) begin
            r.idx = 0; r.has_sel = 0; r.last = 1; r.ovf = ovf;
            pending = {pending, r};
         end else pending[$].last = 1;
         loaded = 0; ovf = 0;
      endfunction

      // compare one result beat with the oldest expected pick
      function void check_pick(pick_type got);
         pick_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result idx=%0d has=%0b last=%0b ovf=%0b",
                     $time, got.idx, got.has_sel, got.last, got.ovf);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.idx !== want.idx) begin
            $display("%0t: selected_index expected %0d actual %0d", $time, want.idx, got.idx);
            errors++;
         end
         if (got.has_sel !== want.has_sel) begin
            $display("%0t: has_selection expected %0b actual %0b", $time, want.has_sel,
                     got.has_sel);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last_result expected %0b actual %0b", $time, want.last, got.last);
            errors++;
         end
         if (got.ovf !== want.ovf) begin
            $display("%0t: overflowed expected %0b actual %0b", $time, want.ovf, got.ovf);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0, req_tuser = 0, req_tlast = 0;
   logic [DW-1:0] req_tdata = '0;
   logic req_tready;
   logic rsp_tvalid, rsp_tlast;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic csr_we = 0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   evict_board board = new();
   bit calm = 0;       // no idling on either side
   bit hold_off = 0;   // long receiver stall requested

   always #5 clock = ~clock;

   lru_eviction_selector #(.MAX_CANDIDATES(NCAND), .NUM_DISKS(NDISK)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata));

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // value with a bias toward edges
   function automatic logic [63:0] pick_value(int scale);
      case ($urandom_range(0, 9))
         0: return 64'd0;
         1: return 64'hFFFF_FFFF_FFFF_FFFF;
         2: return rand64();
         default: return 64'($urandom_range(0, scale));
      endcase
   endfunction

   // receiver: random ready, plus a long counted stall on request
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else begin
         if (rsp_tvalid && rsp_tready)
            board.check_pick('{rsp_tdata[5:0], rsp_tuser[RSP_USER_HAS_SEL], rsp_tlast,
                               rsp_tuser[RSP_USER_OVF]});
         rsp_tready <= !hold_off && (calm || $urandom_range(0, 99) >= 22);
      end
   end

   initial begin : stall_proc
      wait (hold_off);
      repeat (3000) @(posedge clock);
      hold_off = 0;
   end

   task automatic write_deficit(int idx, logic [63:0] val);
      @(posedge clock);
      csr_we <= 1; csr_addr <= idx[CSR_ADDR_W-1:0]; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      board.deficit[idx] = val;
   endtask

   // offer one candidate beat and wait for acceptance
   task automatic send_candidate(logic [63:0] rt, logic [63:0] la, logic p,
                                 logic [63:0] fp[NDISK], logic lst);
      while (!calm && $urandom_range(0, 99) < 22) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {fp[3], fp[2], fp[1], fp[0], la, rt};
      req_tuser <= p;
      req_tlast <= lst;
      do @(posedge clock); while (!req_tready);
      board.note_candidate(rt, la, p, fp, lst);
   endtask

   task automatic send_random(int n, int scale, int pprot);
      logic [63:0] fp[NDISK];
      for (int i = 0; i < n; i++) begin
         for (int d = 0; d < NDISK; d++)
            fp[d] = ($urandom_range(0, 3) == 0) ? 64'd0 : pick_value(scale);
         send_candidate(pick_value(1000), pick_value(1000), $urandom_range(0, 99) < pprot,
                        fp, i == n-1);
      end
   endtask

   // wait for drain, then let the walker settle before touching registers
   task automatic drain();
      int guard;
      guard = 0;
      req_tvalid <= 0;
      while (board.pending.size() != 0 && guard < 200000) begin
         @(posedge clock); guard++;
      end
      repeat (100) @(posedge clock);
   endtask

   task automatic set_deficits(int scale);
      for (int d = 0; d < NDISK; d++)
         write_deficit(d, ($urandom_range(0, 3) == 0) ? 64'd0 : pick_value(scale));
   endtask

   initial begin : main
      logic [63:0] fp[NDISK];
      int items;
      bit pressed;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: all deficits zero gives an empty answer
      fp = '{64'd5, 64'd0, 64'd0, 64'd0};
      send_candidate(64'd0, 64'd0, 0, fp, 1);
      drain();
      write_deficit(0, 64'hFFFF_FFFF_FFFF_FFFF);
      write_deficit(1, 64'd10);
      write_deficit(2, 64'd0);
      write_deficit(3, 64'd1);
      // directed: extremes, ties, protected, saturation, zero footprint
      fp = '{64'hFFFF_FFFF_FFFF_FFFF, 64'd3, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0};
      send_candidate(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 0, fp, 0);
      fp = '{64'hFFFF_FFFF_FFFF_FFFF, 64'd4, 64'd7, 64'd0};
      send_candidate(64'd5, 64'd5, 1, fp, 0);
      fp = '{64'd0, 64'd0, 64'd9, 64'd0};
      send_candidate(64'd5, 64'd2, 0, fp, 0);
      fp = '{64'h8000_0000_0000_0000, 64'd8, 64'd0, 64'd1};
      send_candidate(64'd1, 64'hFFFF_FFFF_FFFF_FFFE, 0, fp, 0);
      fp = '{64'h8000_0000_0000_0000, 64'd0, 64'd0, 64'd0};
      send_candidate(64'd0, 64'd5, 0, fp, 1);
      // single-candidate protected selection
      send_candidate(64'd1, 64'd2, 1, fp, 1);
      drain();

      // directed: overflow, 66 beats with the last two dropped
      write_deficit(0, 64'd1000000);
      calm = 1;
      send_random(66, 100, 10);
      calm = 0;
      drain();

      // random selections with pressure on one of them
      items = 0;
      pressed = 0;
      while (items < 50) begin
         set_deficits(($urandom_range(0, 1) == 0) ? 50 : 5000);
         if (items > 30 && items < 45) calm = 1;
         begin
            int n;
            n = $urandom_range(1, 12);
            send_random(n, 40, 20);
            items += n;
            // second selection offered while the receiver holds off
            if (!pressed && items > 12) begin
               pressed = 1;
               hold_off = 1;
               n = $urandom_range(6, 12);
               send_random(n, 40, 20);
               items += n;
            end
         end
         calm = 0;
         drain();
      end

      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : watchdog
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

### filelist.f
rtl/lrues_pkg.sv
rtl/lrues_front.sv
rtl/lrues_queue.sv
rtl/lrues_back.sv
rtl/lru_eviction_selector.sv
rtl/lrues_checker.sv
verif/testbench.sv
